// File: design/isa_dma_pkg.sv
// Package with port addresses, mode bytes, step codes and helpers for the ISA DMA sequencer.
package isa_dma_pkg;

    localparam int CHANNELS = 8;
    localparam int CHAN_W = 4;
    localparam int ADDR_W = 24;
    localparam int LEN_W = 18;
    localparam int KIND_W = 2;
    localparam int STEP_W = 4;

    // Stream payload widths.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    // Command codes carried in the input tuser.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_END = 1'b1;

    // Port addresses of the byte (first) and word (second) controllers.
    localparam logic [7:0] PORT_MASK_BYTE = 8'h0A;
    localparam logic [7:0] PORT_MODE_BYTE = 8'h0B;
    localparam logic [7:0] PORT_CLR_BYTE = 8'h0C;
    localparam logic [7:0] PORT_MASK_WORD = 8'hD4;
    localparam logic [7:0] PORT_MODE_WORD = 8'hD6;
    localparam logic [7:0] PORT_CLR_WORD = 8'hD8;
    localparam logic [7:0] PORT_ADDR_WORD_BASE = 8'hC0;
    localparam logic [7:0] PORT_CNT_WORD_BASE = 8'hC2;

    // Mask register data: bit 2 set masks the channel.
    localparam logic [7:0] MASK_SET_BIT = 8'h04;

    // Mode bytes per transfer kind.
    localparam logic [1:0] KIND_SINGLE_READ = 2'd0;
    localparam logic [1:0] KIND_SINGLE_WRITE = 2'd1;
    localparam logic [1:0] KIND_AUTO_READ = 2'd2;
    localparam logic [1:0] KIND_AUTO_WRITE = 2'd3;
    localparam logic [7:0] MODE_SINGLE_READ = 8'h48;
    localparam logic [7:0] MODE_SINGLE_WRITE = 8'h44;
    localparam logic [7:0] MODE_AUTO_READ = 8'h58;
    localparam logic [7:0] MODE_AUTO_WRITE = 8'h54;

    // Steps of one programming sequence, in emission order.
    localparam logic [STEP_W-1:0] STEP_MASK = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CLEAR = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MODE = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ADDR_LO = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ADDR_HI = 4'd4;
    localparam logic [STEP_W-1:0] STEP_PAGE = 4'd5;
    localparam logic [STEP_W-1:0] STEP_CNT_LO = 4'd6;
    localparam logic [STEP_W-1:0] STEP_CNT_HI = 4'd7;
    localparam logic [STEP_W-1:0] STEP_UNMASK = 4'd8;

    localparam logic [7:0] ENABLE_RESET = 8'hEB;

    function automatic logic [7:0] mode_byte(input logic [KIND_W-1:0] kind);
        logic [7:0] b;
        case (kind)
            KIND_SINGLE_READ: b = MODE_SINGLE_READ;
            KIND_SINGLE_WRITE: b = MODE_SINGLE_WRITE;
            KIND_AUTO_READ: b = MODE_AUTO_READ;
            KIND_AUTO_WRITE: b = MODE_AUTO_WRITE;
            default: b = MODE_SINGLE_READ;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] page_port(input logic [2:0] ch);
        logic [7:0] p;
        case (ch)
            3'd0: p = 8'h87;
            3'd1: p = 8'h83;
            3'd2: p = 8'h81;
            3'd3: p = 8'h82;
            3'd4: p = 8'h8F;
            3'd5: p = 8'h8B;
            3'd6: p = 8'h89;
            3'd7: p = 8'h8A;
            default: p = 8'h87;
        endcase
        return p;
    endfunction

endpackage

// File: design/isa_dma_channel_program_sequencer.sv
// Top level of the ISA DMA channel program sequencer.
// Each request on the slave stream names a channel and either starts or ends a
// transfer; the block answers on the master stream with the I/O port writes that
// program a PC-style 8237 DMA controller and its page registers. A start gives nine
// writes (mask, clear flip-flop, mode, address low, address high, page, count low,
// count high, unmask), an end gives two (mask, clear flip-flop), and a channel above
// seven or one whose bit in the enable register is clear gives a single error result
// with no write. Channels four to seven are word channels: their address and count
// are in words. The block emits one result per cycle from a held command and a step
// counter, as long as the master stream is not stalled by m_tready; the next request
// is taken in the same cycle that the last result of the current one moves into
// the output register, so commands follow each other without a gap. The enable
// register is written through cfg_we and cfg_wdata; the user must write it only
// while no command is in flight, as the block does not enforce this. It resets to 0xEB.
module isa_dma_channel_program_sequencer (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration: channel enable mask, one bit per channel.
    input  logic                               cfg_we,
    input  logic [7:0]                         cfg_wdata,
    // Command stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: channel[3:0], phys_address[27:4], byte_length[45:28], transfer_kind[47:46]
    input  logic [isa_dma_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: mode[0] (0 start transfer, 1 end transfer)
    input  logic                               s_tuser,
    // Port write stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata: io_port[7:0], io_data[15:8]
    output logic [isa_dma_pkg::M_TDATA_W-1:0]  m_tdata,
    // tuser: write_valid[0], status[1]
    output logic [isa_dma_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                               m_tlast
);
    import isa_dma_pkg::*;

    logic [7:0] enable_reg;

    // Held command and its position in the write sequence.
    logic                 cmd_valid_reg;
    logic                 cmd_mode_reg;
    logic [CHAN_W-1:0]    cmd_chan_reg;
    logic [ADDR_W-1:0]    cmd_addr_reg;
    logic [LEN_W-1:0]     cmd_len_reg;
    logic [KIND_W-1:0]    cmd_kind_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;

    // Output register.
    logic                 out_valid_reg;
    logic [7:0]           out_port_reg;
    logic [7:0]           out_data_reg;
    logic                 out_wv_reg;
    logic                 out_status_reg;
    logic                 out_last_reg;

    logic                 s_accept;
    logic                 out_load;
    logic                 chan_bad;
    logic                 word_ch;
    logic [1:0]           sel;
    logic [7:0]           mask_p;
    logic [7:0]           mode_p;
    logic [7:0]           clr_p;
    logic [7:0]           addr_p;
    logic [7:0]           cnt_p;
    logic [7:0]           addr_lo;
    logic [7:0]           addr_hi;
    logic [LEN_W:0]       len_words;
    logic [15:0]          count;
    logic [7:0]           cur_port;
    logic [7:0]           cur_data;
    logic                 cur_wv;
    logic                 cur_status;
    logic                 cur_last;

    // A channel is unusable when it is out of range or masked off.
    assign chan_bad = cmd_chan_reg[CHAN_W-1] || !enable_reg[cmd_chan_reg[2:0]];
    assign word_ch = cmd_chan_reg[2];
    assign sel = cmd_chan_reg[1:0];

    assign mask_p = word_ch ? PORT_MASK_WORD : PORT_MASK_BYTE;
    assign mode_p = word_ch ? PORT_MODE_WORD : PORT_MODE_BYTE;
    assign clr_p = word_ch ? PORT_CLR_WORD : PORT_CLR_BYTE;
    assign addr_p = word_ch ? (PORT_ADDR_WORD_BASE | {4'd0, sel, 2'b00})
                            : {5'd0, sel, 1'b0};
    assign cnt_p = word_ch ? (PORT_CNT_WORD_BASE | {4'd0, sel, 2'b00})
                           : {5'd0, sel, 1'b1};

    // Word channels address in words, so the byte address shifts down by one.
    assign addr_lo = word_ch ? cmd_addr_reg[8:1] : cmd_addr_reg[7:0];
    assign addr_hi = word_ch ? cmd_addr_reg[16:9] : cmd_addr_reg[15:8];

    // The controller takes the count as units minus one; a zero length wraps.
    assign len_words = ({1'b0, cmd_len_reg} + {{LEN_W{1'b0}}, 1'b1}) >> 1;
    assign count = word_ch ? (len_words[15:0] - 16'd1) : (cmd_len_reg[15:0] - 16'd1);

    always_comb begin
        cur_port = 8'd0;
        cur_data = 8'd0;
        cur_wv = 1'b1;
        cur_status = 1'b0;
        cur_last = 1'b0;
        if (chan_bad) begin
            cur_wv = 1'b0;
            cur_status = 1'b1;
            cur_last = 1'b1;
        end else begin
            case (step_reg)
                STEP_MASK: begin
                    cur_port = mask_p;
                    cur_data = MASK_SET_BIT | {6'd0, sel};
                end
                STEP_CLEAR: begin
                    cur_port = clr_p;
                    cur_last = (cmd_mode_reg == CMD_END);
                end
                STEP_MODE: begin
                    cur_port = mode_p;
                    cur_data = mode_byte(cmd_kind_reg) | {6'd0, sel};
                end
                STEP_ADDR_LO: begin
                    cur_port = addr_p;
                    cur_data = addr_lo;
                end
                STEP_ADDR_HI: begin
                    cur_port = addr_p;
                    cur_data = addr_hi;
                end
                STEP_PAGE: begin
                    cur_port = page_port(cmd_chan_reg[2:0]);
                    cur_data = cmd_addr_reg[23:16];
                end
                STEP_CNT_LO: begin
                    cur_port = cnt_p;
                    cur_data = count[7:0];
                end
                STEP_CNT_HI: begin
                    cur_port = cnt_p;
                    cur_data = count[15:8];
                end
                STEP_UNMASK: begin
                    cur_port = mask_p;
                    cur_data = {6'd0, sel};
                    cur_last = 1'b1;
                end
                default: begin
                    cur_port = mask_p;
                    cur_data = {6'd0, sel};
                    cur_last = 1'b1;
                end
            endcase
        end
    end

    // The output register takes a result whenever it is empty or being drained.
    assign out_load = cmd_valid_reg && (!out_valid_reg || m_tready);
    // A new request enters as soon as the held one hands over its last result.
    assign s_tready = !cmd_valid_reg || (out_load && cur_last);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        step_next = step_reg;
        if (out_load) begin
            step_next = cur_last ? STEP_MASK : step_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= ENABLE_RESET;
            cmd_valid_reg <= 1'b0;
            step_reg <= STEP_MASK;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                enable_reg <= cfg_wdata;
            end
            step_reg <= step_next;
            if (s_accept) begin
                cmd_valid_reg <= 1'b1;
            end else if (out_load && cur_last) begin
                cmd_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_mode_reg <= s_tuser;
            cmd_chan_reg <= s_tdata[3:0];
            cmd_addr_reg <= s_tdata[27:4];
            cmd_len_reg <= s_tdata[45:28];
            cmd_kind_reg <= s_tdata[47:46];
        end
        if (out_load) begin
            out_port_reg <= cur_port;
            out_data_reg <= cur_data;
            out_wv_reg <= cur_wv;
            out_status_reg <= cur_status;
            out_last_reg <= cur_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {out_data_reg, out_port_reg};
    assign m_tuser = {out_status_reg, out_wv_reg};
    assign m_tlast = out_last_reg;

    // With no command held the block must always be able to take a request.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd_valid_reg |-> s_tready)
        else $error("request refused while no command is held");

    // The step counter returns to the first step after each final result.
    a_step_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && cur_last |=> step_reg == STEP_MASK)
        else $error("step counter did not restart after a final result");

    // The step counter never runs past the unmask write.
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid_reg |-> step_reg <= STEP_UNMASK)
        else $error("step counter out of range");

    // An end command stops after the clear flip-flop write.
    a_end_short: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid_reg && cmd_mode_reg == CMD_END |-> step_reg <= STEP_CLEAR)
        else $error("end command ran past its second write");

    // An error result carries no write and closes the command.
    a_error_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
        else $error("error result carries a write or is not final");

endmodule
